@@ hw/rtl/length_prefixed_frame_receiver_unit_assert.svh @@
// Assertion macros for the frame receiver checker.
// Both sample on clk and are disabled while rst_n is low.
`ifndef LENGTH_PREFIXED_FRAME_RECEIVER_UNIT_ASSERT_SVH
`define LENGTH_PREFIXED_FRAME_RECEIVER_UNIT_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define LPFR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define LPFR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/lpfr_pkg.sv @@
package lpfr_pkg;

    localparam int BUF_DEPTH_DEF = 256;

    // request codes
    localparam logic [1:0] CMD_LINE  = 2'd0;
    localparam logic [1:0] CMD_POP   = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_TX     = 2'd1;
    localparam logic [1:0] KIND_POP    = 2'd2;

    // frame bytes
    localparam logic [7:0] FC_SUB_A = 8'h80;
    localparam logic [7:0] FC_SUB_B = 8'h81;
    localparam logic [7:0] FC_ACK   = 8'h40;
    localparam logic [7:0] SUB_RX   = 8'h03;
    localparam logic [7:0] ACK_B0   = 8'h02;
    localparam logic [7:0] ACK_B1   = 8'h40;

    typedef struct packed {
        logic       push;
        logic       send_ack;
    } parse_ev_t;

    typedef struct packed {
        logic       pop_ok;
        logic       empty;
        logic       overflow;
    } ring_stat_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       pair;
        logic       empty;
        logic       overflow;
        logic [7:0] ack_count;
    } res_item_t;

endpackage

@@ hw/rtl/length_prefixed_frame_receiver_unit.sv @@
// Length-prefixed frame receiver. Each request (line byte, buffer pop or
// acknowledge-count clear) gives one registered result in the next cycle,
// or two results in turn for a frame-ending byte that sends the 0x02 0x40
// acknowledge. Sustained rate is one request per cycle while out_stall is
// low; a request with two results holds the input until both are taken.
// The single output register sets this. Received data bytes sit in a BUF_DEPTH
// byte store with a registered read port; popped data is read at acceptance
// and presented with the result. The store needs no clearing after reset.
module length_prefixed_frame_receiver_unit
    import lpfr_pkg::*;
#(
    parameter int BUF_DEPTH = BUF_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] cmd,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] kind,
    output logic [7:0] data,
    output logic       last,
    output logic       buffer_empty,
    output logic       overflow,
    output logic [7:0] ack_count
);

    logic       acc;
    logic       line_en, pop_en, clear_en;
    parse_ev_t  ev;
    logic [7:0] ack_next;
    ring_stat_t stat;
    logic [7:0] rd_data;
    res_item_t  item;

    assign acc      = in_valid && !in_stall;
    assign line_en  = acc && (cmd == CMD_LINE);
    assign pop_en   = acc && (cmd == CMD_POP);
    assign clear_en = acc && (cmd == CMD_CLEAR);

    lpfr_parser u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .line_en        (line_en),
        .clear_en       (clear_en),
        .rx_byte        (rx_byte),
        .ev             (ev),
        .ack_count_next (ack_next)
    );

    lpfr_ring #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_ring (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (ev.push),
        .push_data (rx_byte),
        .pop       (pop_en),
        .stat      (stat),
        .rd_data   (rd_data)
    );

    always_comb
    begin
        item.kind      = KIND_STATUS;
        item.data      = 8'd0;
        item.pair      = 1'b0;
        item.empty     = stat.empty;
        item.overflow  = stat.overflow;
        item.ack_count = ack_next;
        if (line_en && ev.send_ack)
        begin
            item.kind = KIND_TX;
            item.data = ACK_B0;
            item.pair = 1'b1;
        end
        else if (stat.pop_ok)
            item.kind = KIND_POP;
    end

    lpfr_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (acc),
        .item         (item),
        .rd_data      (rd_data),
        .out_stall    (out_stall),
        .hold         (in_stall),
        .out_valid    (out_valid),
        .kind         (kind),
        .data         (data),
        .last         (last),
        .buffer_empty (buffer_empty),
        .overflow     (overflow),
        .ack_count    (ack_count)
    );

endmodule

@@ hw/rtl/lpfr_parser.sv @@
module lpfr_parser
    import lpfr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       line_en,
    input  logic       clear_en,
    input  logic [7:0] rx_byte,
    output parse_ev_t  ev,
    output logic [7:0] ack_count_next
);

    typedef enum logic [1:0] {PH_LEN, PH_CMD, PH_SUB, PH_DATA} phase_t;

    phase_t     phase_reg, phase_next;
    logic [8:0] left_reg, left_next, left_load;
    logic [7:0] cmd_reg, cmd_next;
    logic [7:0] sub_reg, sub_next;
    logic [7:0] ack_reg, ack_next;

    always_comb
    begin
        phase_next = phase_reg;
        left_load  = left_reg;
        left_next  = left_reg;
        cmd_next   = cmd_reg;
        sub_next   = sub_reg;
        ack_next   = ack_reg;
        ev         = '0;
        if (line_en)
        begin
            unique case (phase_reg)
                PH_LEN:
                begin
                    // zero length means a 256 byte frame
                    left_load  = (rx_byte == 8'd0) ? 9'd256 : {1'b0, rx_byte};
                    phase_next = PH_CMD;
                end
                PH_CMD:
                begin
                    cmd_next   = rx_byte;
                    sub_next   = 8'd0;
                    phase_next = (rx_byte == FC_SUB_A || rx_byte == FC_SUB_B) ?
                                 PH_SUB : PH_DATA;
                end
                PH_SUB:
                begin
                    sub_next   = rx_byte;
                    phase_next = PH_DATA;
                end
                PH_DATA:
                begin
                    ev.push = (sub_reg == SUB_RX);
                end
            endcase
            left_next = left_load - 9'd1;
            if (left_next == 9'd0)
            begin
                if (cmd_next == FC_ACK)
                begin
                    if (ack_reg != 8'hFF)
                        ack_next = ack_reg + 8'd1;
                end
                else
                    ev.send_ack = 1'b1;
                phase_next = PH_LEN;
                cmd_next   = 8'd0;
                sub_next   = 8'd0;
            end
        end
        if (clear_en)
            ack_next = 8'd0;
    end

    assign ack_count_next = ack_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LEN;
            left_reg  <= '0;
            cmd_reg   <= '0;
            sub_reg   <= '0;
            ack_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            cmd_reg   <= cmd_next;
            sub_reg   <= sub_next;
            ack_reg   <= ack_next;
        end
    end

endmodule

@@ hw/rtl/lpfr_ring.sv @@
module lpfr_ring
    import lpfr_pkg::*;
#(
    parameter int BUF_DEPTH = BUF_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic [7:0] push_data,
    input  logic       pop,
    output ring_stat_t stat,
    output logic [7:0] rd_data
);

    localparam int AW = $clog2(BUF_DEPTH);
    localparam int CW = $clog2(BUF_DEPTH + 1);

    logic [7:0]    mem [BUF_DEPTH];
    logic [AW-1:0] wr_reg, wr_next;
    logic [AW-1:0] rd_reg, rd_next;
    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic [7:0]    rd_data_reg;
    logic          full, push_ok, pop_ok;

    assign full    = (count_reg == CW'(BUF_DEPTH));
    assign push_ok = push && !full;
    assign pop_ok  = pop && (count_reg != '0);

    always_comb
    begin
        wr_next    = wr_reg;
        rd_next    = rd_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg | (push && full);
        if (push_ok)
        begin
            wr_next    = (wr_reg == AW'(BUF_DEPTH - 1)) ? '0 : wr_reg + AW'(1);
            count_next = count_reg + CW'(1);
        end
        if (pop_ok)
        begin
            rd_next    = (rd_reg == AW'(BUF_DEPTH - 1)) ? '0 : rd_reg + AW'(1);
            count_next = count_reg - CW'(1);
        end
    end

    // store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (push_ok)
            mem[wr_reg] <= push_data;
        if (pop_ok)
            rd_data_reg <= mem[rd_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    assign stat.pop_ok   = pop_ok;
    assign stat.empty    = (count_next == '0);
    assign stat.overflow = ovf_next;
    assign rd_data       = rd_data_reg;

endmodule

@@ hw/rtl/lpfr_out.sv @@
module lpfr_out
    import lpfr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  res_item_t  item,
    input  logic [7:0] rd_data,
    input  logic       out_stall,
    output logic       hold,
    output logic       out_valid,
    output logic [1:0] kind,
    output logic [7:0] data,
    output logic       last,
    output logic       buffer_empty,
    output logic       overflow,
    output logic [7:0] ack_count
);

    logic       valid_reg;
    logic       pair_reg;
    logic [1:0] kind_reg;
    logic [7:0] data_reg;
    logic       empty_reg;
    logic       ovf_reg;
    logic [7:0] ack_reg;
    logic       take;

    assign take = valid_reg && !out_stall;
    // a two-result request keeps the register until its second result is taken
    assign hold = valid_reg && (out_stall || pair_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pair_reg  <= 1'b0;
            kind_reg  <= KIND_STATUS;
            empty_reg <= 1'b1;
            ovf_reg   <= 1'b0;
            ack_reg   <= '0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            pair_reg  <= item.pair;
            kind_reg  <= item.kind;
            empty_reg <= item.empty;
            ovf_reg   <= item.overflow;
            ack_reg   <= item.ack_count;
        end
        else if (take)
        begin
            if (pair_reg)
                pair_reg <= 1'b0;
            else
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= item.data;
        else if (take && pair_reg)
            data_reg <= ACK_B1;
    end

    assign out_valid    = valid_reg;
    assign kind         = kind_reg;
    assign data         = (kind_reg == KIND_POP) ? rd_data : data_reg;
    assign last         = !pair_reg;
    assign buffer_empty = empty_reg;
    assign overflow     = ovf_reg;
    assign ack_count    = ack_reg;

endmodule

@@ hw/rtl/lpfr_checker.sv @@
`include "length_prefixed_frame_receiver_unit_assert.svh"

module lpfr_checker
    import lpfr_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] kind,
    input logic [7:0] data,
    input logic       last,
    input logic       buffer_empty,
    input logic       overflow,
    input logic [7:0] ack_count
);

    logic [20:0] payload;
    logic        held;
    logic        status;
    logic        ack_head;
    logic        ack_tail;

    assign payload  = {kind, data, last, buffer_empty, overflow, ack_count};
    assign held     = out_valid && out_stall;
    assign status   = out_valid && kind == KIND_STATUS;
    assign ack_head = out_valid && kind == KIND_TX && !last;
    assign ack_tail = out_valid && kind == KIND_TX && last && data == ACK_B1;

    `LPFR_ASSERT_NEXT(a_out_hold, held, out_valid && $stable(payload), "stalled result changed")
    `LPFR_ASSERT_SAME(a_status_zero, status, data == 8'd0 && last, "status result carries data")
    `LPFR_ASSERT_NEXT(a_ack_pair, ack_head && !out_stall, ack_tail, "acknowledge pair broken")
    `LPFR_ASSERT_SAME(a_ack_first, ack_head, data == ACK_B0, "first acknowledge byte wrong")
    `LPFR_ASSERT_SAME(a_ovf_sticky, 1'b1, !$fell(overflow), "overflow flag cleared")

endmodule

bind length_prefixed_frame_receiver_unit lpfr_checker u_lpfr_checker (.*);

@@ dv/tb_length_prefixed_frame_receiver_unit.sv @@
`timescale 1ns / 1ps

module tb_length_prefixed_frame_receiver_unit;
    import lpfr_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int RING_DEPTH = BUF_DEPTH_DEF;
    localparam int PTR_W = $clog2(RING_DEPTH) + 1;
    localparam logic [PTR_W-1:0] RING_FULL = PTR_W'(RING_DEPTH);
    // watchdog limit for a stretch with no handshake while work is outstanding
    localparam int QUIET_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_REPORTS = 50;

    typedef enum logic [1:0] {AWAIT_LEN, AWAIT_CMD, AWAIT_SUB, IN_DATA} rx_phase_t;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] octet;
    } request_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
        logic       empty;
        logic       ovf;
        logic [7:0] acks;
    } rx_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [1:0] cmd = CMD_LINE;
    logic [7:0] rx_byte = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
    logic       buffer_empty;
    logic       overflow;
    logic [7:0] ack_count;

    // predictor state
    rx_phase_t        frame_ph = AWAIT_LEN;
    logic [8:0]       bytes_to_go = '0;
    logic [7:0]       cur_cmd = '0;
    logic [7:0]       cur_sub = '0;
    logic [7:0]       ring [RING_DEPTH];
    logic [PTR_W-1:0] wr_ptr = '0;
    logic [PTR_W-1:0] rd_ptr = '0;
    logic [7:0]       acks_seen = '0;
    logic             ovf_seen = 1'b0;

    request_t   pending_requests[$];
    rx_result_t expected_rx_results[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int n_queued = 0;
    int n_sent = 0;
    int n_results = 0;
    int n_tx = 0;
    int n_popped = 0;
    int n_fail = 0;
    int quiet_cycles = 0;

    length_prefixed_frame_receiver_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .data         (data),
        .last         (last),
        .buffer_empty (buffer_empty),
        .overflow     (overflow),
        .ack_count    (ack_count)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // status fields reflect the state after the step
    task automatic note_result(input logic [1:0] k, input logic [7:0] d, input logic lst);
        rx_result_t r;
        r.kind = k;
        r.data = d;
        r.last = lst;
        r.empty = (wr_ptr == rd_ptr);
        r.ovf = ovf_seen;
        r.acks = acks_seen;
        expected_rx_results.push_back(r);
    endtask

    task automatic predict_frame_rx(input logic [1:0] op, input logic [7:0] b);
        logic             send_ack;
        logic [PTR_W-1:0] fill;
        logic [7:0]       popped;
        send_ack = 1'b0;
        fill = wr_ptr - rd_ptr;
        case (op)
            CMD_LINE:
            begin
                case (frame_ph)
                    AWAIT_LEN:
                    begin
                        bytes_to_go = (b == 8'd0) ? 9'd256 : {1'b0, b};
                        frame_ph = AWAIT_CMD;
                    end
                    AWAIT_CMD:
                    begin
                        cur_cmd = b;
                        cur_sub = 8'd0;
                        frame_ph = (b == FC_SUB_A || b == FC_SUB_B) ? AWAIT_SUB : IN_DATA;
                    end
                    AWAIT_SUB:
                    begin
                        cur_sub = b;
                        frame_ph = IN_DATA;
                    end
                    default:
                    begin
                        if (cur_sub == SUB_RX)
                        begin
                            if (fill == RING_FULL)
                                ovf_seen = 1'b1;
                            else
                            begin
                                ring[wr_ptr[PTR_W-2:0]] = b;
                                wr_ptr = wr_ptr + 1'b1;
                            end
                        end
                    end
                endcase
                bytes_to_go = bytes_to_go - 9'd1;
                if (bytes_to_go == 9'd0)
                begin
                    if (cur_cmd == FC_ACK)
                    begin
                        if (acks_seen != 8'hFF)
                            acks_seen = acks_seen + 8'd1;
                    end
                    else
                        send_ack = 1'b1;
                    frame_ph = AWAIT_LEN;
                    cur_cmd = 8'd0;
                    cur_sub = 8'd0;
                end
                if (send_ack)
                begin
                    note_result(KIND_TX, ACK_B0, 1'b0);
                    note_result(KIND_TX, ACK_B1, 1'b1);
                end
                else
                    note_result(KIND_STATUS, 8'd0, 1'b1);
            end
            CMD_POP:
            begin
                if (fill != '0)
                begin
                    popped = ring[rd_ptr[PTR_W-2:0]];
                    rd_ptr = rd_ptr + 1'b1;
                    note_result(KIND_POP, popped, 1'b1);
                end
                else
                    note_result(KIND_STATUS, 8'd0, 1'b1);
            end
            CMD_CLEAR:
            begin
                acks_seen = 8'd0;
                note_result(KIND_STATUS, 8'd0, 1'b1);
            end
            default:
                note_result(KIND_STATUS, 8'd0, 1'b1);
        endcase
    endtask

    task automatic add_req(input logic [1:0] op, input logic [7:0] octet);
        request_t rq;
        rq.op = op;
        rq.octet = octet;
        pending_requests.push_back(rq);
        if (op != CMD_UNUSED)
            n_queued++;
    endtask

    // well-formed frame: length, command, subcommand where the command takes one, data
    task automatic add_frame(input logic [7:0] len, input logic [7:0] fc, input logic [7:0] sub);
        int total;
        total = (len == 8'd0) ? 256 : int'(len);
        add_req(CMD_LINE, len);
        for (int i = 1; i < total; i++)
        begin
            if (i == 1)
                add_req(CMD_LINE, fc);
            else if (i == 2 && (fc == FC_SUB_A || fc == FC_SUB_B))
                add_req(CMD_LINE, sub);
            else
                add_req(CMD_LINE, 8'($urandom));
        end
    endtask

    task automatic add_random_seq();
        int         pick;
        int         len_pick;
        logic [7:0] len;
        logic [7:0] fc;
        logic [7:0] sub;
        pick = $urandom_range(99);
        if (pick < 55)
        begin
            len_pick = $urandom_range(99);
            if (len_pick < 85)
                len = 8'($urandom_range(12, 1));
            else if (len_pick < 96)
                len = 8'($urandom_range(40, 13));
            else
                len = ($urandom_range(1) != 0) ? 8'd0 : 8'd255;
            case ($urandom_range(3))
                0: fc = FC_SUB_A;
                1: fc = FC_SUB_B;
                2: fc = FC_ACK;
                default: fc = 8'($urandom);
            endcase
            sub = ($urandom_range(2) != 0) ? SUB_RX : 8'($urandom);
            add_frame(len, fc, sub);
        end
        else if (pick < 78)
            repeat ($urandom_range(6, 1)) add_req(CMD_POP, 8'($urandom));
        else if (pick < 82)
            add_req(CMD_CLEAR, 8'($urandom));
        else
            add_req(2'($urandom), 8'($urandom));  // stray request, may break framing
    endtask

    task automatic add_random(input int budget);
        int target;
        target = n_queued + budget;
        while (n_queued < target)
            add_random_seq();
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (pending_requests.size() != 0 || in_valid || expected_rx_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [7:0] want_v,
                               input logic [7:0] got_v);
        if (got_v !== want_v)
        begin
            if (n_fail < MAX_REPORTS)
                $error("%s: expected 0x%02h, actual 0x%02h", name, want_v, got_v);
            n_fail++;
        end
    endtask

    always @(posedge clk)
    begin : drive_requests
        request_t nxt;
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_frame_rx(cmd, rx_byte);
                n_sent++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = pending_requests.pop_front();
                    in_valid <= 1'b1;
                    cmd <= nxt.op;
                    rx_byte <= nxt.octet;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        rx_result_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                n_results++;
                if (kind == KIND_TX)
                    n_tx++;
                if (kind == KIND_POP)
                    n_popped++;
                if (expected_rx_results.size() == 0)
                begin
                    if (n_fail < MAX_REPORTS)
                        $error("unexpected result: kind %0d data 0x%02h", kind, data);
                    n_fail++;
                end
                else
                begin
                    want = expected_rx_results.pop_front();
                    check_field("kind", 8'(want.kind), 8'(kind));
                    check_field("data", want.data, data);
                    check_field("last", 8'(want.last), 8'(last));
                    check_field("buffer_empty", 8'(want.empty), 8'(buffer_empty));
                    check_field("overflow", 8'(want.ovf), 8'(overflow));
                    check_field("ack_count", want.acks, ack_count);
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else if (pending_requests.size() != 0 || in_valid ||
                     expected_rx_results.size() != 0)
            begin
                quiet_cycles <= quiet_cycles + 1;
                if (quiet_cycles + 1 >= QUIET_LIMIT)
                begin
                    $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                             QUIET_LIMIT, expected_rx_results.size());
                    $display("Simulation FAILED");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed part, no idling
        add_req(CMD_POP, 8'hFF);            // pop on empty buffer
        add_req(CMD_UNUSED, 8'hAA);
        add_req(CMD_CLEAR, 8'h55);
        add_req(CMD_LINE, 8'h01);           // frame ends on its own length byte
        add_frame(8'd2, FC_ACK, 8'h00);
        add_req(CMD_LINE, 8'h05);
        add_req(CMD_LINE, FC_SUB_A);
        add_req(CMD_LINE, SUB_RX);
        add_req(CMD_LINE, 8'h00);
        add_req(CMD_LINE, 8'hFF);
        add_frame(8'd4, FC_SUB_B, 8'h07);   // wrong subcommand, nothing stored
        add_frame(8'd3, 8'h11, 8'h00);
        repeat (3) add_req(CMD_POP, 8'h00);
        add_req(CMD_CLEAR, 8'h00);
        add_frame(8'd3, FC_SUB_A, SUB_RX);  // ends on the subcommand
        // drive the ack counter into saturation, then clear it
        repeat (256) add_frame(8'd2, FC_ACK, 8'h00);
        add_req(CMD_CLEAR, 8'h00);
        wait_drained();

        send_idle_pct = 75;
        recv_stall_pct = 0;
        add_random(20);
        wait_drained();

        send_idle_pct = 0;
        recv_stall_pct = 75;
        add_random(20);
        wait_drained();

        send_idle_pct = 33;
        recv_stall_pct = 33;
        add_random(15);
        // a full-length frame plus a short one overruns the ring, then pop a few bytes
        add_frame(8'd0, FC_SUB_B, SUB_RX);
        add_frame(8'd8, FC_SUB_A, SUB_RX);
        repeat (6) add_req(CMD_POP, 8'($urandom));
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("%0d requests sent, %0d results checked (%0d ack bytes, %0d popped bytes)",
                 n_sent, n_results, n_tx, n_popped);
        $display("covered ack counter saturation, ring overflow and four idling mixes;");
        $display("%0d mismatches", n_fail);
        if (n_fail == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
